>>> hdl/lrc_pkg.sv
// ----------------------------------------------------------------------------
// lrc_pkg
// Shared types, constants and per-term divider tables for the lidar point
// converter.
// ----------------------------------------------------------------------------
package lrc_pkg;

  localparam int CHANNELS_DEF   = 64;
  localparam int TRIG_FRAC_DEF  = 15;

  localparam int FULL_TURN      = 36000;
  localparam int QUARTER_TURN   = 9000;
  localparam int HALF_TURN      = 18000;

  // PI_Q30 = HALF_TURN * PI_QUOT + PI_REM
  localparam int PI_QUOT        = 187403;
  localparam int PI_REM         = 5426;
  localparam logic [26:0] RECIP_HALF_TURN = 27'd122167958; // floor(2^41/18000)
  localparam int RECIP_HT_SHIFT = 41;

  localparam int N_TERMS        = 8;
  localparam int RECIP_SHIFT    = 33;
  localparam int SINE_LAT       = 4 + 2 * N_TERMS + 1;

  localparam int COORD_W        = 19;
  localparam int RMM_W          = 18;

  typedef struct packed {
    logic [31:0]        x2;
    logic [30:0]        term;
    logic signed [33:0] sum;
    logic               neg;
  } lrc_term_t;

  // divisor (2k)(2k+1) of Taylor term k
  function automatic logic [8:0] term_div(input int k);
    logic [8:0] d;
    case (k)
      1:       d = 9'd6;
      2:       d = 9'd20;
      3:       d = 9'd42;
      4:       d = 9'd72;
      5:       d = 9'd110;
      6:       d = 9'd156;
      7:       d = 9'd210;
      default: d = 9'd272;
    endcase
    return d;
  endfunction

  // floor(2^33 / divisor); numerators stay below 2^33
  function automatic logic [30:0] term_recip(input int k);
    logic [30:0] m;
    case (k)
      1:       m = 31'd1431655765;
      2:       m = 31'd429496729;
      3:       m = 31'd204522252;
      4:       m = 31'd119304647;
      5:       m = 31'd78090314;
      6:       m = 31'd55063683;
      7:       m = 31'd40904450;
      default: m = 31'd31580641;
    endcase
    return m;
  endfunction

endpackage

>>> hdl/lrc_if.sv
// ----------------------------------------------------------------------------
// lrc_if
// Channel interfaces: return/load items, point items, register writes.
// ----------------------------------------------------------------------------
interface lrc_in_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic [5:0]         ring;
  logic [15:0]        azimuth_raw;
  logic [15:0]        distance_raw;
  logic [7:0]         confidence;
  logic signed [13:0] vert_angle_cdeg;
  logic signed [15:0] azimuth_corr_cdeg;

  modport source (output valid, operation, ring, azimuth_raw, distance_raw, confidence,
                  vert_angle_cdeg, azimuth_corr_cdeg, input ready);
  modport sink   (input valid, operation, ring, azimuth_raw, distance_raw, confidence,
                  vert_angle_cdeg, azimuth_corr_cdeg, output ready);
endinterface

interface lrc_out_if;
  logic               valid;
  logic               ready;
  logic               point_valid;
  logic signed [18:0] x_mm;
  logic signed [18:0] y_mm;
  logic signed [18:0] z_mm;
  logic [7:0]         intensity;
  logic [5:0]         ring_out;

  modport source (output valid, point_valid, x_mm, y_mm, z_mm, intensity, ring_out,
                  input ready);
  modport sink   (input valid, point_valid, x_mm, y_mm, z_mm, intensity, ring_out,
                  output ready);
endinterface

interface lrc_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

>>> hdl/lrc_ram.sv
// ----------------------------------------------------------------------------
// lrc_ram
// Generic single-write, single-read RAM with registered read.
// ----------------------------------------------------------------------------
module lrc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hdl/lrc_cell.sv
// ----------------------------------------------------------------------------
// lrc_cell
// One Taylor term: term' = ((term*x2)>>30)/((2k)(2k+1)), subtracted from (odd k) or added to (even k) the sum.
// ----------------------------------------------------------------------------
module lrc_cell
  import lrc_pkg::*;
#(
  parameter int K = 1
) (
  input  logic      clk,
  input  logic      en,
  input  lrc_term_t din,
  output lrc_term_t dout
);

  localparam logic [8:0]  D = term_div(K);
  localparam logic [30:0] M = term_recip(K);

  logic [62:0] prod;
  lrc_term_t   hold;
  logic [32:0] n;
  logic [63:0] qm;
  logic [30:0] q0;
  logic [32:0] rem;
  logic [30:0] q;

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= 63'(din.term) * 63'(din.x2);
      hold <= din;
    end
  end

  always_comb begin
    n   = prod[62:30];
    qm  = 64'(n) * 64'(M);
    q0  = qm[RECIP_SHIFT+30:RECIP_SHIFT];
    rem = n - 33'(33'(q0) * 33'(D));
    q   = (rem >= 33'(D)) ? q0 + 31'd1 : q0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout.x2   <= hold.x2;
      dout.neg  <= hold.neg;
      dout.term <= q;
      if (K % 2 == 1) begin
        dout.sum <= hold.sum - $signed({3'b000, q});
      end else begin
        dout.sum <= hold.sum + $signed({3'b000, q});
      end
    end
  end

endmodule

>>> hdl/lrc_sine.sv
// ----------------------------------------------------------------------------
// lrc_sine
// Pipelined sine of an angle in centidegrees: quadrant fold, Q30 radians,
// chain of Taylor cells, round to QF. Returns magnitude and sign.
// ----------------------------------------------------------------------------
module lrc_sine
  import lrc_pkg::*;
#(
  parameter int TRIG_FRAC_BITS = TRIG_FRAC_DEF
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [15:0]               angle,
  output logic [TRIG_FRAC_BITS-1:0] mag,
  output logic                      neg
);

  localparam int F = TRIG_FRAC_BITS;

  logic [15:0] t;
  logic [13:0] r;
  logic [13:0] fold;
  logic        q_neg;
  logic [13:0] rr_a;
  logic        neg_a;
  logic [31:0] prod_b;
  logic [25:0] num_b;
  logic        neg_b;
  logic [52:0] qm;
  logic [11:0] q0;
  logic [25:0] rem;
  logic [11:0] qc;
  logic [30:0] x_c;
  logic        neg_c;
  logic [61:0] xsq;
  logic [33:0] s_pos;
  logic [33:0] s_rnd;
  lrc_term_t   chain [N_TERMS+1];

  always_comb begin
    t = (angle >= 16'(FULL_TURN)) ? angle - 16'(FULL_TURN) : angle;
    if (t < 16'(QUARTER_TURN)) begin
      r = t[13:0]; fold = r; q_neg = 1'b0;
    end else if (t < 16'(HALF_TURN)) begin
      r = 14'(t - 16'(QUARTER_TURN)); fold = 14'(QUARTER_TURN) - r; q_neg = 1'b0;
    end else if (t < 16'(HALF_TURN + QUARTER_TURN)) begin
      r = 14'(t - 16'(HALF_TURN)); fold = r; q_neg = 1'b1;
    end else begin
      r = 14'(t - 16'(HALF_TURN + QUARTER_TURN)); fold = 14'(QUARTER_TURN) - r;
      q_neg = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rr_a  <= fold;
      neg_a <= q_neg;
      prod_b <= 32'(rr_a) * 32'(PI_QUOT);
      num_b  <= 26'(26'(rr_a) * 26'(PI_REM)) + 26'(QUARTER_TURN);
      neg_b  <= neg_a;
      x_c    <= 31'(prod_b + 32'(qc));
      neg_c  <= neg_b;
    end
  end

  // rounded divide by HALF_TURN
  always_comb begin
    qm  = 53'(num_b) * 53'(RECIP_HALF_TURN);
    q0  = qm[RECIP_HT_SHIFT+11:RECIP_HT_SHIFT];
    rem = num_b - 26'(26'(q0) * 26'(HALF_TURN));
    qc  = (rem >= 26'(HALF_TURN)) ? q0 + 12'd1 : q0;
    xsq = 62'(x_c) * 62'(x_c);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      chain[0].x2   <= xsq[61:30];
      chain[0].term <= x_c;
      chain[0].sum  <= $signed({3'b000, x_c});
      chain[0].neg  <= neg_c;
    end
  end

  for (genvar k = 1; k <= N_TERMS; k++) begin : g_cell
    lrc_cell #(.K(k)) u_cell (
      .clk  (clk),
      .en   (en),
      .din  (chain[k-1]),
      .dout (chain[k])
    );
  end

  always_comb begin
    s_pos = chain[N_TERMS].sum[33] ? '0 : chain[N_TERMS].sum;
    s_rnd = (s_pos + (34'd1 << (29 - F))) >> (30 - F);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag <= (s_rnd > 34'((1 << F) - 1)) ? F'((1 << F) - 1) : s_rnd[F-1:0];
      neg <= chain[N_TERMS].neg;
    end
  end

endmodule

>>> hdl/lidar_return_to_cartesian.sv
// ----------------------------------------------------------------------------
// lidar_return_to_cartesian
// Converts lidar returns into Cartesian points using per-ring calibration.
//
// din carries items: operation 1 loads the ring's vertical angle and azimuth
// correction into the calibration RAM and yields no point; operation 0
// converts a return into one point item on dout. cfg writes the mount
// rotation (centidegrees); write it only while the block is idle.
// Throughput is one item per cycle while dout does not stall. A point is
// registered through the RAM read at the accepting edge, the angle stage,
// the 21-stage sine chain of eight Taylor cells and three projection stages
// including the output register.
// The whole pipeline advances together: when dout stalls with a point
// waiting, din.ready drops and every stage holds; while the output register
// is empty or being taken, din.ready stays high.
// Reset (rst, synchronous) clears the pipeline valid bits and the rotation;
// calibration RAM content is not cleared, a ring must be loaded before use.
// ----------------------------------------------------------------------------
module lidar_return_to_cartesian
  import lrc_pkg::*;
#(
  parameter int CHANNELS       = CHANNELS_DEF,
  parameter int TRIG_FRAC_BITS = TRIG_FRAC_DEF
) (
  input  logic          clk,
  input  logic          rst,
  lrc_in_if.sink        din,
  lrc_out_if.source     dout,
  lrc_cfg_if.sink       cfg
);

  localparam int F  = TRIG_FRAC_BITS;
  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int XY_W = RMM_W + F;
  localparam int HI_W = XY_W - 20;

  logic        adv;
  logic [15:0] rotation;
  logic        acc;
  logic [AW-1:0] addr;
  logic        in_rng;
  logic [29:0] cal;

  // stage 1
  logic        v1, rng1;
  logic [5:0]  ring1;
  logic [15:0] az1, dist1;
  logic [7:0]  conf1;
  // stage 2
  logic        v2;
  logic [15:0] at2, vt2;
  logic [5:0]  ring2;
  logic [7:0]  conf2;
  logic [RMM_W-1:0] rmm2;

  logic [16:0] s_sum;
  logic [16:0] s_mod;
  logic signed [17:0] az_c;
  logic signed [17:0] az_w;
  logic [15:0] at_c, vt_c;
  logic signed [13:0] vcal;
  logic signed [15:0] acal;

  logic [F-1:0] sa_m, ca_m, sv_m, cv_m;
  logic         sa_n, ca_n, sv_n, cv_n;

  logic [SINE_LAT-1:0] vs;
  logic [5:0]  ring_d [SINE_LAT];
  logic [7:0]  conf_d [SINE_LAT];
  logic [RMM_W-1:0] rmm_d [SINE_LAT];

  // projection stages
  logic        vp1, vp2;
  logic [XY_W-1:0] xy1;
  logic [XY_W-1:0] zp1;
  logic [F-1:0] sa1, ca1;
  logic        sx1, sy1, sz1;
  logic [5:0]  ring_p1, ring_p2;
  logic [7:0]  conf_p1, conf_p2;
  logic [2*F+20:0] lox2, loy2;
  logic [HI_W+F-1:0] hix2, hiy2;
  logic [XY_W-1:0] zm2;
  logic        sx2, sy2, sz2;

  logic [HI_W+F:0] sumx, sumy;
  logic [COORD_W-1:0] mx, my, mz;
  logic signed [COORD_W-1:0] xv, yv, zv;

  assign adv       = !dout.valid || dout.ready;
  assign din.ready = adv;
  assign acc       = din.valid && adv;
  assign cfg.ready = 1'b1;
  assign addr      = AW'(din.ring);
  assign in_rng    = 32'(din.ring) < 32'(CHANNELS);

  always_ff @(posedge clk) begin
    if (rst) begin
      rotation <= '0;
    end else if (cfg.valid) begin
      rotation <= cfg.data;
    end
  end

  lrc_ram #(.WIDTH(30), .DEPTH(CHANNELS)) u_cal (
    .clk     (clk),
    .wr_en   (acc && din.operation && in_rng),
    .wr_addr (addr),
    .wr_data ({din.vert_angle_cdeg, din.azimuth_corr_cdeg}),
    .rd_en   (adv),
    .rd_addr (addr),
    .rd_data (cal)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      ring1 <= din.ring;
      az1   <= din.azimuth_raw;
      dist1 <= din.distance_raw;
      conf1 <= din.confidence;
      rng1  <= in_rng;
    end
  end

  always_comb begin
    vcal  = rng1 ? $signed(cal[29:16]) : '0;
    acal  = rng1 ? $signed(cal[15:0])  : '0;
    s_sum = 17'(az1) + 17'(rotation);
    if (s_sum >= 17'(3 * FULL_TURN)) begin
      s_mod = s_sum - 17'(3 * FULL_TURN);
    end else if (s_sum >= 17'(2 * FULL_TURN)) begin
      s_mod = s_sum - 17'(2 * FULL_TURN);
    end else if (s_sum >= 17'(FULL_TURN)) begin
      s_mod = s_sum - 17'(FULL_TURN);
    end else begin
      s_mod = s_sum;
    end
    az_c = $signed({1'b0, s_mod}) + 18'(acal);
    if (az_c < 0) begin
      az_w = az_c + 18'sd36000;
    end else if (az_c >= 18'sd36000) begin
      az_w = az_c - 18'sd36000;
    end else begin
      az_w = az_c;
    end
    at_c = az_w[15:0];
    vt_c = (vcal < 0) ? 16'(17'(vcal) + 17'(FULL_TURN)) : 16'(vcal);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      at2   <= at_c;
      vt2   <= vt_c;
      ring2 <= ring1;
      conf2 <= conf1;
      rmm2  <= {dist1, 2'b00};
    end
  end

  lrc_sine #(.TRIG_FRAC_BITS(F)) u_sa (
    .clk(clk), .en(adv), .angle(at2), .mag(sa_m), .neg(sa_n));
  lrc_sine #(.TRIG_FRAC_BITS(F)) u_ca (
    .clk(clk), .en(adv), .angle(at2 + 16'(QUARTER_TURN)), .mag(ca_m), .neg(ca_n));
  lrc_sine #(.TRIG_FRAC_BITS(F)) u_sv (
    .clk(clk), .en(adv), .angle(vt2), .mag(sv_m), .neg(sv_n));
  lrc_sine #(.TRIG_FRAC_BITS(F)) u_cv (
    .clk(clk), .en(adv), .angle(vt2 + 16'(QUARTER_TURN)), .mag(cv_m), .neg(cv_n));

  always_ff @(posedge clk) begin
    if (adv) begin
      ring_d[0] <= ring2;
      conf_d[0] <= conf2;
      rmm_d[0]  <= rmm2;
      for (int i = 1; i < SINE_LAT; i++) begin
        ring_d[i] <= ring_d[i-1];
        conf_d[i] <= conf_d[i-1];
        rmm_d[i]  <= rmm_d[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      xy1     <= XY_W'(rmm_d[SINE_LAT-1]) * XY_W'(cv_m);
      zp1     <= XY_W'(XY_W'(rmm_d[SINE_LAT-1]) * XY_W'(sv_m)) + (XY_W'(1) << (F - 1));
      sa1     <= sa_m;
      ca1     <= ca_m;
      sx1     <= cv_n ^ sa_n;
      sy1     <= cv_n ^ ca_n;
      sz1     <= sv_n;
      ring_p1 <= ring_d[SINE_LAT-1];
      conf_p1 <= conf_d[SINE_LAT-1];

      lox2    <= (2*F+21)'(xy1[19:0]) * (2*F+21)'(sa1) + ((2*F+21)'(1) << (2*F - 1));
      loy2    <= (2*F+21)'(xy1[19:0]) * (2*F+21)'(ca1) + ((2*F+21)'(1) << (2*F - 1));
      hix2    <= (HI_W+F)'(xy1[XY_W-1:20]) * (HI_W+F)'(sa1);
      hiy2    <= (HI_W+F)'(xy1[XY_W-1:20]) * (HI_W+F)'(ca1);
      zm2     <= zp1 >> F;
      sx2     <= sx1;
      sy2     <= sy1;
      sz2     <= sz1;
      ring_p2 <= ring_p1;
      conf_p2 <= conf_p1;
    end
  end

  always_comb begin
    sumx = (HI_W+F+1)'(hix2) + (HI_W+F+1)'(lox2 >> 20);
    sumy = (HI_W+F+1)'(hiy2) + (HI_W+F+1)'(loy2 >> 20);
    mx   = COORD_W'(sumx >> (2*F - 20));
    my   = COORD_W'(sumy >> (2*F - 20));
    mz   = COORD_W'(zm2);
    xv   = sx2 ? -$signed(mx) : $signed(mx);
    yv   = sy2 ? -$signed(my) : $signed(my);
    zv   = sz2 ? -$signed(mz) : $signed(mz);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dout.x_mm        <= xv;
      dout.y_mm        <= yv;
      dout.z_mm        <= zv;
      dout.point_valid <= (xv != '0) || (yv != '0) || (zv != '0);
      dout.intensity   <= conf_p2;
      dout.ring_out    <= ring_p2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1         <= 1'b0;
      v2         <= 1'b0;
      vs         <= '0;
      vp1        <= 1'b0;
      vp2        <= 1'b0;
      dout.valid <= 1'b0;
    end else if (adv) begin
      v1         <= acc && !din.operation;
      v2         <= v1;
      vs         <= {vs[SINE_LAT-2:0], v2};
      vp1        <= vs[SINE_LAT-1];
      vp2        <= vp1;
      dout.valid <= vp2;
    end
  end

endmodule

>>> hdl/lrc_checker.sv
// ----------------------------------------------------------------------------
// lrc_checker
// Port-level checks on the converter, bound to the top level.
// ----------------------------------------------------------------------------
module lrc_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               point_valid,
  input logic signed [18:0] x_mm,
  input logic signed [18:0] y_mm,
  input logic signed [18:0] z_mm,
  input logic               cfg_ready
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(x_mm) && $stable(y_mm)
                                && $stable(z_mm))
    else $error("point changed while stalled");

  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid || out_ready |-> in_ready)
    else $error("input blocked with free output");

  a_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> point_valid == ((x_mm != 0) || (y_mm != 0) || (z_mm != 0)))
    else $error("point_valid disagrees with coordinates");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("item out after reset");

  a_cfg: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("cfg not ready");

endmodule

bind lidar_return_to_cartesian lrc_checker u_lrc_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (din.ready),
  .out_valid   (dout.valid),
  .out_ready   (dout.ready),
  .point_valid (dout.point_valid),
  .x_mm        (dout.x_mm),
  .y_mm        (dout.y_mm),
  .z_mm        (dout.z_mm),
  .cfg_ready   (cfg.ready)
);

>>> sim/lrc_tb_if.sv
// ----------------------------------------------------------------------------
// lrc_tb_if
// Testbench-side view of the channel interfaces: the channels are the
// interfaces of hdl/lrc_if.sv, compiled with the RTL. This file only holds
// the item and point types of the stimulus and expected queues and the opcodes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package lrc_tb_pkg;
  typedef struct packed {
    logic               operation;
    logic [5:0]         ring;
    logic [15:0]        azimuth_raw;
    logic [15:0]        distance_raw;
    logic [7:0]         confidence;
    logic signed [13:0] vert_angle_cdeg;
    logic signed [15:0] azimuth_corr_cdeg;
  } lidar_item_t;

  typedef struct packed {
    logic               point_valid;
    logic signed [18:0] x_mm;
    logic signed [18:0] y_mm;
    logic signed [18:0] z_mm;
    logic [7:0]         intensity;
    logic [5:0]         ring_out;
  } point_t;

  localparam logic OP_CONVERT = 1'b0;
  localparam logic OP_LOAD    = 1'b1;
endpackage

>>> sim/lidar_return_to_cartesian_tb.sv
// ----------------------------------------------------------------------------
// lidar_return_to_cartesian_tb
// Streams calibration loads and returns into the converter under random
// idling and a long output hold-off, predicts each point with an own
// fixed-point trig model and checks every point item in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module lidar_return_to_cartesian_tb;
  import lrc_pkg::*;
  import lrc_tb_pkg::*;

  localparam int FB        = 15;
  localparam int LATENCY   = 25;
  localparam longint PI30  = 64'd3373259426;
  localparam int MAX_CYC   = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #6 clk = ~clk;

  lrc_in_if  din();
  lrc_out_if dout();
  lrc_cfg_if cfg();

  lidar_return_to_cartesian DUT (.clk(clk), .rst(rst), .din(din), .dout(dout), .cfg(cfg));

  lidar_item_t pending_items[$];
  point_t      expected_points[$];
  logic [15:0] rotation;
  logic signed [13:0] vcal_tab [64];
  logic signed [15:0] acal_tab [64];
  bit          loaded [64];
  int          errors = 0;
  int          cycles = 0;
  bit          quiet = 1'b0;
  int          in_gap = 0, out_gap = 0, hold_off = 0;

  function automatic longint sine_quadrant(longint r);
    longint x, x2, term, sum, q;
    x = (r * PI30 + 9000) / 18000;
    x2 = (x * x) >>> 30;
    term = x;
    sum = x;
    for (int k = 1; k <= 8; k++) begin
      term = ((term * x2) >>> 30) / ((2 * k) * (2 * k + 1));
      if (k % 2) sum -= term; else sum += term;
    end
    if (sum < 0) sum = 0;
    q = (sum + (64'd1 << (29 - FB))) >>> (30 - FB);
    if (q > (1 << FB) - 1) q = (1 << FB) - 1;
    return q;
  endfunction

  function automatic longint sine_cdeg(longint t);
    longint q, r;
    t = t % 36000;
    q = t / 9000;
    r = t % 9000;
    case (q)
      0: return sine_quadrant(r);
      1: return sine_quadrant(9000 - r);
      2: return -sine_quadrant(r);
      default: return -sine_quadrant(9000 - r);
    endcase
  endfunction

  function automatic longint abs64(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic point_t convert_return(lidar_item_t it);
    point_t p;
    longint vc, ac, az, vt, rmm, cv, sv, sa, ca, x, y, z;
    vc = vcal_tab[it.ring];
    ac = acal_tab[it.ring];
    az = (longint'(it.azimuth_raw) + rotation) % 36000 + ac;
    if (az < 0) az += 36000;
    az = az % 36000;
    vt = vc < 0 ? vc + 36000 : vc;
    rmm = longint'(it.distance_raw) * 4;
    cv = sine_cdeg(vt + 9000);
    sv = sine_cdeg(vt);
    sa = sine_cdeg(az);
    ca = sine_cdeg(az + 9000);
    x = (rmm * abs64(cv) * abs64(sa) + (64'd1 << (2 * FB - 1))) >>> (2 * FB);
    if ((cv < 0) != (sa < 0)) x = -x;
    y = (rmm * abs64(cv) * abs64(ca) + (64'd1 << (2 * FB - 1))) >>> (2 * FB);
    if ((cv < 0) != (ca < 0)) y = -y;
    z = (rmm * abs64(sv) + (64'd1 << (FB - 1))) >>> FB;
    if (sv < 0) z = -z;
    p.point_valid = (x != 0 || y != 0 || z != 0);
    p.x_mm = x[18:0];
    p.y_mm = y[18:0];
    p.z_mm = z[18:0];
    p.intensity = it.confidence;
    p.ring_out = it.ring;
    return p;
  endfunction

  function automatic lidar_item_t rand_item(bit load, int ring);
    lidar_item_t it;
    it.operation = load ? OP_LOAD : OP_CONVERT;
    it.ring = 6'(ring);
    it.azimuth_raw = 16'($urandom);
    it.distance_raw = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 20)) :
                      16'($urandom);
    it.confidence = 8'($urandom);
    it.vert_angle_cdeg = ($urandom_range(0, 7) == 0) ? 14'($urandom) :
                         14'($signed($urandom_range(0, 10000)) - 5000);
    it.azimuth_corr_cdeg = ($urandom_range(0, 7) == 0) ? 16'($urandom) :
                           16'($signed($urandom_range(0, 36000)) - 18000);
    return it;
  endfunction

  // loads and converts in flight are predicted at acceptance, in order
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYC) begin
      $display("CHECK FAILED");
      $finish;
    end
    if (!rst) begin
      if (din.valid && din.ready) begin
        lidar_item_t cur;
        cur = {din.operation, din.ring, din.azimuth_raw, din.distance_raw, din.confidence,
               din.vert_angle_cdeg, din.azimuth_corr_cdeg};
        if (cur.operation == OP_LOAD) begin
          vcal_tab[cur.ring] = cur.vert_angle_cdeg;
          acal_tab[cur.ring] = cur.azimuth_corr_cdeg;
        end else
          expected_points = {expected_points, convert_return(cur)};
        void'(pending_items.pop_front());
      end
      if (din.valid && !din.ready) begin
        din.valid <= 1'b1;
      end else if (pending_items.size() != 0 && (quiet || in_gap == 0)) begin
        {din.operation, din.ring, din.azimuth_raw, din.distance_raw, din.confidence,
         din.vert_angle_cdeg, din.azimuth_corr_cdeg} <= pending_items[0];
        din.valid <= 1'b1;
        if (!quiet && $urandom_range(0, 9) == 0) in_gap <= $urandom_range(1, 15);
      end else begin
        din.valid <= 1'b0;
        if (in_gap > 0) in_gap <= in_gap - 1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (dout.valid && dout.ready) begin
        point_t got, exp_p;
        got = {dout.point_valid, dout.x_mm, dout.y_mm, dout.z_mm, dout.intensity,
               dout.ring_out};
        if (expected_points.size() == 0) begin
          errors++;
          $display("%0t unexpected point %h", $time, got);
        end else begin
          exp_p = expected_points.pop_front();
          if (got !== exp_p) begin
            errors++;
            $display("%0t point mismatch: expected pv=%0d x=%0d y=%0d z=%0d i=%0d r=%0d",
                     $time, exp_p.point_valid, exp_p.x_mm, exp_p.y_mm, exp_p.z_mm,
                     exp_p.intensity, exp_p.ring_out);
            $display("%0t                 actual   pv=%0d x=%0d y=%0d z=%0d i=%0d r=%0d",
                     $time, got.point_valid, got.x_mm, got.y_mm, got.z_mm,
                     got.intensity, got.ring_out);
          end
        end
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        dout.ready <= 1'b0;
      end else if (quiet) dout.ready <= 1'b1;
      else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        dout.ready <= 1'b0;
      end else begin
        dout.ready <= 1'b1;
        if ($urandom_range(0, 9) == 0) out_gap <= $urandom_range(1, 15);
      end
    end
  end

  task automatic write_rotation(logic [15:0] value);
    @(posedge clk);
    cfg.data <= value;
    cfg.valid <= 1'b1;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    rotation = value;
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || expected_points.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic queue_returns(int n);
    int rg;
    for (int i = 0; i < n; i++) begin
      rg = $urandom_range(0, 63);
      if (!loaded[rg] || $urandom_range(0, 9) == 0) begin
        pending_items = {pending_items, rand_item(1, rg)};
        loaded[rg] = 1;
      end else pending_items = {pending_items, rand_item(0, rg)};
    end
  endtask

  initial begin
    lidar_item_t it;
    din.valid = 1'b0; din.operation = 1'b0; din.ring = 6'd0; din.azimuth_raw = 16'd0;
    din.distance_raw = 16'd0; din.confidence = 8'd0; din.vert_angle_cdeg = 14'sd0;
    din.azimuth_corr_cdeg = 16'sd0;
    dout.ready = 1'b0;
    cfg.valid = 1'b0; cfg.data = 16'd0;
    rotation = 16'd0;
    foreach (loaded[i]) begin loaded[i] = 0; vcal_tab[i] = 14'sd0; acal_tab[i] = 16'sd0; end
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    write_rotation(16'd0);
    // extremes of calibration and fields
    it = rand_item(1, 0);  it.vert_angle_cdeg = -14'sd8192; it.azimuth_corr_cdeg = -16'sd32768;
    pending_items = {pending_items, it};
    it = rand_item(1, 63); it.vert_angle_cdeg = 14'sd8191;  it.azimuth_corr_cdeg = 16'sd32767;
    pending_items = {pending_items, it};
    it = rand_item(1, 5);  it.vert_angle_cdeg = 14'sd0; it.azimuth_corr_cdeg = 16'sd0;
    pending_items = {pending_items, it};
    it = rand_item(1, 6);  it.vert_angle_cdeg = 14'sd5000; it.azimuth_corr_cdeg = -16'sd18000;
    pending_items = {pending_items, it};
    loaded[0] = 1; loaded[63] = 1; loaded[5] = 1; loaded[6] = 1;
    for (int r = 0; r < 4; r++) begin
      int rg;
      rg = (r == 0) ? 0 : (r == 1) ? 63 : (r == 2) ? 5 : 6;
      it = rand_item(0, rg); it.distance_raw = 16'hFFFF; it.azimuth_raw = 16'hFFFF;
      it.confidence = 8'hFF; pending_items = {pending_items, it};
      it = rand_item(0, rg); it.distance_raw = 16'd0; it.azimuth_raw = 16'd0;
      it.confidence = 8'd0; pending_items = {pending_items, it};
      it = rand_item(0, rg); it.distance_raw = 16'd1; it.azimuth_raw = 16'd9000;
      pending_items = {pending_items, it};
    end
    drain();

    write_rotation(16'd36000);
    queue_returns(250);
    // long output hold-off while input keeps being offered
    while (expected_points.size() < 10) @(posedge clk);
    hold_off = 300;
    drain();
    write_rotation(16'hFFFF);
    queue_returns(250);
    drain();
    write_rotation(16'($urandom_range(0, 36000)));
    queue_returns(250);
    drain();
    quiet = 1'b1;
    write_rotation(16'd18000);
    queue_returns(250);
    drain();

    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
